@@ hdl/filtered_trace_ring_buffer_macros.svh @@
// Assertion macros shared by the trace ring buffer modules.
`ifndef FILTERED_TRACE_RING_BUFFER_MACROS_SVH
`define FILTERED_TRACE_RING_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define FTRB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define FTRB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/ftrb_pkg.sv @@
// Types and constants shared by the trace ring buffer modules.
`timescale 1ns / 1ps

package ftrb_pkg;

   // Field widths.
   localparam int unsigned CTR_W   = 48;
   localparam int unsigned CNT_W   = 7;
   localparam int unsigned ID_W    = 22;
   localparam int unsigned STATE_W = 32;
   localparam int unsigned NAME_W  = 64;

   // Input item kinds.
   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Filter modes; the unused code behaves as off.
   localparam logic [1:0] FILT_OFF   = 2'd0;
   localparam logic [1:0] FILT_ALL   = 2'd1;
   localparam logic [1:0] FILT_GROUP = 2'd2;

   // Exit states that override any other recorded state.
   localparam logic [7:0] QUIT_ZOMBIE = 8'd32;
   localparam logic [7:0] QUIT_DEAD   = 8'd16;

   // Register indexes on the configuration port.
   localparam logic REG_FILTER_MODE  = 1'b0;
   localparam logic REG_FILTER_GROUP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EVAL,
      ST_START,
      ST_FETCH,
      ST_OUT
   } ctrl_state_type;

   // Why an answer is being evaluated.
   typedef enum logic [1:0] {
      ANS_CHECK,
      ANS_READ,
      ANS_FORCE
   } ans_type;

   // Outcome of evaluating a read target against the total.
   typedef enum logic [1:0] {
      EV_NONE,
      EV_PARK,
      EV_BUSY,
      EV_RUN
   } eval_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         quit_state;
      logic [STATE_W-1:0] option_state;
      logic [STATE_W-1:0] task_state;
      logic [ID_W-1:0]    group_id;
      logic [ID_W-1:0]    thread_id;
      logic [NAME_W-1:0]  name_low;
      logic [NAME_W-1:0]  name_high;
      logic [CTR_W-1:0]   request_counter;
   } req_type;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [ID_W-1:0]    group_id;
      logic [ID_W-1:0]    thread_id;
      logic [NAME_W-1:0]  name_low;
      logic [NAME_W-1:0]  name_high;
   } entry_type;

   typedef struct packed {
      entry_type        entry;
      logic             has_entry;
      logic [CNT_W-1:0] entry_count;
      logic [CTR_W-1:0] new_counter;
      logic             status;
      logic             last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic eval;
      logic start;
      logic fetch;
      logic advance;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] kind;
      logic       add_pass;
      logic       pend;
      logic       req_zero;
      eval_type   eval_res;
      logic       run_empty;
      logic       last_beat;
   } sts_type;

endpackage

@@ hdl/ftrb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ftrb_ram #(
   parameter int unsigned WIDTH = 204,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/ftrb_ctrl.sv @@
// Controller state machine that sequences each item through the datapath.
`timescale 1ns / 1ps
`include "filtered_trace_ring_buffer_macros.svh"

module ftrb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  ftrb_pkg::sts_type sts,
   output ftrb_pkg::cmd_type cmd
);
   import ftrb_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            priority if (sts.kind == KIND_ADD) begin
               state_in = (sts.add_pass && sts.pend) ? ST_EVAL : ST_IDLE;
            end else if (sts.kind == KIND_READ) begin
               state_in = sts.req_zero ? ST_START : ST_EVAL;
            end else if (sts.kind == KIND_CLEAR) begin
               state_in = sts.pend ? ST_EVAL : ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EVAL: begin
            unique case (sts.eval_res)
               EV_NONE: state_in = ST_IDLE;
               EV_PARK: state_in = ST_IDLE;
               EV_BUSY: state_in = ST_OUT;
               EV_RUN:  state_in = ST_START;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_START: begin
            state_in = sts.run_empty ? ST_OUT : ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = sts.last_beat ? ST_IDLE : ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output decode.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC:  cmd.exec  = 1'b1;
         ST_EVAL:  cmd.eval  = 1'b1;
         ST_START: cmd.start = 1'b1;
         ST_FETCH: cmd.fetch = 1'b1;
         ST_OUT: begin
            rsp_valid   = 1'b1;
            cmd.advance = !rsp_stall && !sts.last_beat;
         end
         default: ;
      endcase
   end

   `FTRB_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state_ff == ST_EXEC, "accepted beat did not start execution")
   `FTRB_ASSERT_NEXT(a_out_hold, (state_ff == ST_OUT) && rsp_stall, state_ff == ST_OUT, "stalled result left the output state")
   `FTRB_ASSERT_SAME(a_eval_order, state_ff == ST_EVAL, $past(state_ff) == ST_EXEC, "evaluation not preceded by execution")

endmodule

@@ hdl/ftrb_dp.sv @@
// Datapath: ring pointers, totals, pending slot, entry store and result registers.
`timescale 1ns / 1ps
`include "filtered_trace_ring_buffer_macros.svh"

module ftrb_dp #(
   parameter int unsigned RING_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ftrb_pkg::cmd_type          cmd,
   output ftrb_pkg::sts_type          sts,
   input  ftrb_pkg::req_type          req,
   input  logic [1:0]                 filter_mode,
   input  logic [ftrb_pkg::ID_W-1:0]  filter_group_id,
   output ftrb_pkg::rsp_type          rsp
);
   import ftrb_pkg::*;

   localparam int unsigned IW = $clog2(RING_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);
   localparam logic [CTR_W-1:0] DEPTH_CTR = CTR_W'(RING_DEPTH);

   req_type          in_ff;
   logic [IW-1:0]    head_ff;
   logic [IW-1:0]    tail_ff;
   logic             empty_ff;
   logic [CTR_W-1:0] total_ff;
   logic             pend_ff;
   logic [CTR_W-1:0] ptgt_ff;
   logic [CTR_W-1:0] tgt_ff;
   ans_type          mode_ff;
   logic [CNT_W-1:0] limit_ff;
   logic [CTR_W-1:0] ctr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] remain_ff;
   logic [IW-1:0]    rd_idx_ff;
   logic             has_ff;
   logic             status_ff;

   logic             pass_w;
   logic [STATE_W-1:0] state_w;
   logic [CTR_W:0]   diff_w;
   logic             borrow_w;
   logic             stale_w;
   logic [CTR_W:0]   sum_w;
   logic [CTR_W-1:0] sat_tgt_w;
   logic [CNT_W-1:0] held_w;
   logic [CNT_W-1:0] count_w;
   logic [CNT_W-1:0] zero_limit_w;
   logic             last_w;
   eval_type         eval_w;
   logic             ram_we;
   entry_type        wr_entry;
   entry_type        rd_entry;
   logic [$bits(entry_type)-1:0] ram_rdata;

   function automatic logic [IW-1:0] nxt_idx(input logic [IW-1:0] i);
      logic [IW-1:0] n;
      n = (i == IW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
      return n;
   endfunction

   // Trace filter and recorded state selection.
   always_comb begin
      pass_w = (filter_mode == FILT_ALL) ||
               ((filter_mode == FILT_GROUP) && (in_ff.group_id == filter_group_id));
      if ((in_ff.quit_state == QUIT_ZOMBIE) || (in_ff.quit_state == QUIT_DEAD)) begin
         state_w = {{(STATE_W - 8){1'b0}}, in_ff.quit_state};
      end else if (in_ff.option_state != '0) begin
         state_w = in_ff.option_state;
      end else begin
         state_w = in_ff.task_state;
      end
   end

   // Read target, saturated at the counter's top value.
   always_comb begin
      sum_w     = {1'b0, in_ff.request_counter} + (CTR_W + 1)'(RING_DEPTH);
      sat_tgt_w = sum_w[CTR_W] ? {CTR_W{1'b1}} : sum_w[CTR_W-1:0];
      zero_limit_w = (total_ff < DEPTH_CTR) ? total_ff[CNT_W-1:0] : DEPTH_CNT;
   end

   // Compare the target against the running total.
   always_comb begin
      diff_w   = {1'b0, total_ff} - {1'b0, tgt_ff};
      borrow_w = diff_w[CTR_W];
      stale_w  = diff_w[CTR_W-1:0] >= DEPTH_CTR;
      eval_w   = EV_RUN;
      if (borrow_w) begin
         unique case (mode_ff)
            ANS_CHECK: eval_w = EV_NONE;
            ANS_READ:  eval_w = pend_ff ? EV_BUSY : EV_PARK;
            ANS_FORCE: eval_w = EV_RUN;
            default:   eval_w = EV_NONE;
         endcase
      end
   end

   // Entries held in the ring and the length of the run.
   always_comb begin
      if (empty_ff) begin
         held_w = '0;
      end else if (head_ff == tail_ff) begin
         held_w = DEPTH_CNT;
      end else if (tail_ff > head_ff) begin
         held_w = CNT_W'(tail_ff) - CNT_W'(head_ff);
      end else begin
         held_w = DEPTH_CNT - CNT_W'(head_ff) + CNT_W'(tail_ff);
      end
      count_w = (held_w < limit_ff) ? held_w : limit_ff;
      last_w  = !has_ff || (remain_ff == CNT_W'(1));
   end

   // Ring state, pending slot and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         empty_ff  <= 1'b1;
         total_ff  <= '0;
         pend_ff   <= 1'b0;
         ptgt_ff   <= '0;
         status_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            in_ff <= req;
         end

         // Execute the accepted item.
         if (cmd.exec) begin
            unique case (in_ff.kind)
               KIND_ADD: begin
                  mode_ff <= ANS_CHECK;
                  tgt_ff  <= ptgt_ff;
                  if (pass_w) begin
                     total_ff <= total_ff + 1'b1;
                     tail_ff  <= nxt_idx(tail_ff);
                     if (empty_ff) begin
                        empty_ff <= 1'b0;
                     end else if (head_ff == tail_ff) begin
                        head_ff <= nxt_idx(head_ff);
                     end
                  end
               end
               KIND_READ: begin
                  mode_ff <= ANS_READ;
                  if (in_ff.request_counter == '0) begin
                     limit_ff <= zero_limit_w;
                     ctr_ff   <= total_ff;
                  end else begin
                     tgt_ff <= sat_tgt_w;
                  end
               end
               KIND_CLEAR: begin
                  mode_ff <= ANS_FORCE;
                  tgt_ff  <= ptgt_ff;
                  if (!pend_ff) begin
                     head_ff  <= tail_ff;
                     empty_ff <= 1'b1;
                  end
               end
               default: ;
            endcase
         end

         // Decide how the read is answered.
         if (cmd.eval) begin
            unique case (eval_w)
               EV_NONE: ;
               EV_PARK: begin
                  pend_ff <= 1'b1;
                  ptgt_ff <= tgt_ff;
               end
               EV_BUSY: begin
                  has_ff    <= 1'b0;
                  status_ff <= 1'b1;
                  cnt_ff    <= '0;
                  ctr_ff    <= '0;
               end
               EV_RUN: begin
                  if (mode_ff != ANS_READ) begin
                     pend_ff <= 1'b0;
                  end
                  if (borrow_w) begin
                     limit_ff <= DEPTH_CNT;
                     ctr_ff   <= tgt_ff;
                  end else if (stale_w) begin
                     limit_ff <= '0;
                     ctr_ff   <= total_ff;
                  end else begin
                     limit_ff <= DEPTH_CNT - diff_w[CNT_W-1:0];
                     ctr_ff   <= tgt_ff;
                  end
               end
               default: ;
            endcase
         end

         // Start the run from the oldest entry; a clear that answers a parked read empties the ring here.
         if (cmd.start) begin
            cnt_ff    <= count_w;
            remain_ff <= count_w;
            rd_idx_ff <= head_ff;
            has_ff    <= (count_w != '0);
            status_ff <= 1'b0;
            if (mode_ff == ANS_FORCE) begin
               head_ff  <= tail_ff;
               empty_ff <= 1'b1;
            end
         end

         // Step to the next entry after a beat is taken.
         if (cmd.advance) begin
            rd_idx_ff <= nxt_idx(rd_idx_ff);
            remain_ff <= remain_ff - 1'b1;
         end
      end
   end

   // Entry store.
   assign ram_we = cmd.exec && (in_ff.kind == KIND_ADD) && pass_w;

   always_comb begin
      wr_entry.state     = state_w;
      wr_entry.group_id  = in_ff.group_id;
      wr_entry.thread_id = in_ff.thread_id;
      wr_entry.name_low  = in_ff.name_low;
      wr_entry.name_high = in_ff.name_high;
   end

   ftrb_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (RING_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (tail_ff),
      .wdata (wr_entry),
      .re    (cmd.fetch),
      .raddr (rd_idx_ff),
      .rdata (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   // Result beat.
   always_comb begin
      rsp.entry       = has_ff ? rd_entry : '0;
      rsp.has_entry   = has_ff;
      rsp.entry_count = cnt_ff;
      rsp.new_counter = ctr_ff;
      rsp.status      = status_ff;
      rsp.last        = last_w;
   end

   // Status to the controller.
   always_comb begin
      sts.kind      = in_ff.kind;
      sts.add_pass  = pass_w;
      sts.pend      = pend_ff;
      sts.req_zero  = (in_ff.request_counter == '0);
      sts.eval_res  = eval_w;
      sts.run_empty = (count_w == '0);
      sts.last_beat = last_w;
   end

   `FTRB_ASSERT_SAME(a_empty_ptrs, empty_ff, head_ff == tail_ff, "empty ring, pointers differ")
   `FTRB_ASSERT_SAME(a_busy_no_entry, status_ff, !has_ff && (cnt_ff == '0), "busy with entry")
   `FTRB_ASSERT_SAME(a_advance_remain, cmd.advance, remain_ff > CNT_W'(1), "advance past run end")

endmodule

@@ hdl/filtered_trace_ring_buffer.sv @@
// Top level of the filtered trace ring buffer with its configuration registers.
`timescale 1ns / 1ps

// Filtered trace ring buffer. Add beats that pass the trace filter are stored
// in a ring of RING_DEPTH entries, overwriting the oldest when full; read beats
// return a run of entries from the oldest, and a read that must wait parks in
// one pending slot until a later add or clear answers it. Items are handled one
// at a time. An add is executed, and is then evaluated when it is checked against
// a pending read. A read or clear that answers passes through execution, then
// evaluation where it needs one, and the start of its run; each entry is then
// fetched from the store, whose read data is registered, before its beat is
// offered, and the next fetch waits until that beat is taken. An empty or busy
// answer is one beat offered right after setup. An answer run holds at most
// RING_DEPTH beats. The filter registers are at byte offsets 0 (mode) and
// 4 (group id) and read back their values.
module filtered_trace_ring_buffer #(
   parameter int unsigned RING_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [7:0]                    req_quit_state,
   input  logic [ftrb_pkg::STATE_W-1:0]  req_option_state,
   input  logic [ftrb_pkg::STATE_W-1:0]  req_task_state,
   input  logic [ftrb_pkg::ID_W-1:0]     req_group_id,
   input  logic [ftrb_pkg::ID_W-1:0]     req_thread_id,
   input  logic [ftrb_pkg::NAME_W-1:0]   req_name_low,
   input  logic [ftrb_pkg::NAME_W-1:0]   req_name_high,
   input  logic [ftrb_pkg::CTR_W-1:0]    req_request_counter,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ftrb_pkg::STATE_W-1:0]  rsp_out_state,
   output logic [ftrb_pkg::ID_W-1:0]     rsp_out_group_id,
   output logic [ftrb_pkg::ID_W-1:0]     rsp_out_thread_id,
   output logic [ftrb_pkg::NAME_W-1:0]   rsp_out_name_low,
   output logic [ftrb_pkg::NAME_W-1:0]   rsp_out_name_high,
   output logic                          rsp_has_entry,
   output logic [ftrb_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic [ftrb_pkg::CTR_W-1:0]    rsp_new_counter,
   output logic                          rsp_status,
   output logic                          rsp_last,

   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import ftrb_pkg::*;

   logic [1:0]      fmode_ff;
   logic [ID_W-1:0] fgroup_ff;
   logic            csr_wr;
   logic            csr_idx;
   req_type         req;
   rsp_type         rsp;
   cmd_type         cmd;
   sts_type         sts;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         fmode_ff  <= FILT_OFF;
         fgroup_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FILTER_MODE:  fmode_ff  <= csr_pwdata[1:0];
            REG_FILTER_GROUP: fgroup_ff <= csr_pwdata[ID_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_idx)
         REG_FILTER_MODE:  csr_prdata = {30'd0, fmode_ff};
         REG_FILTER_GROUP: csr_prdata = {{(32 - ID_W){1'b0}}, fgroup_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Gather the input beat.
   always_comb begin
      req.kind            = req_kind;
      req.quit_state      = req_quit_state;
      req.option_state    = req_option_state;
      req.task_state      = req_task_state;
      req.group_id        = req_group_id;
      req.thread_id       = req_thread_id;
      req.name_low        = req_name_low;
      req.name_high       = req_name_high;
      req.request_counter = req_request_counter;
   end

   ftrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ftrb_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req             (req),
      .filter_mode     (fmode_ff),
      .filter_group_id (fgroup_ff),
      .rsp             (rsp)
   );

   // Spread the result beat onto its ports.
   assign rsp_out_state     = rsp.entry.state;
   assign rsp_out_group_id  = rsp.entry.group_id;
   assign rsp_out_thread_id = rsp.entry.thread_id;
   assign rsp_out_name_low  = rsp.entry.name_low;
   assign rsp_out_name_high = rsp.entry.name_high;
   assign rsp_has_entry     = rsp.has_entry;
   assign rsp_entry_count   = rsp.entry_count;
   assign rsp_new_counter   = rsp.new_counter;
   assign rsp_status        = rsp.status;
   assign rsp_last          = rsp.last;

endmodule

@@ sim/filtered_trace_ring_buffer_tb.sv @@
// Self-checking testbench for the filtered trace ring buffer.
`timescale 1ns / 1ps

module filtered_trace_ring_buffer_tb;
   import ftrb_pkg::*;

   localparam int DEPTH         = 64;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 16;

   // Codes that the package leaves unnamed.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] FILT_UNUSED = 2'd3;
   localparam logic       STATUS_OK   = 1'b0;
   localparam logic       STATUS_BUSY = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request channel.
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       beat_on_bus = '0;
   logic [1:0]    req_kind;
   logic [7:0]    req_quit_state;
   logic [31:0]   req_option_state;
   logic [31:0]   req_task_state;
   logic [21:0]   req_group_id;
   logic [21:0]   req_thread_id;
   logic [63:0]   req_name_low;
   logic [63:0]   req_name_high;
   logic [47:0]   req_request_counter;

   // Answer channel.
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [31:0]   rsp_out_state;
   logic [21:0]   rsp_out_group_id;
   logic [21:0]   rsp_out_thread_id;
   logic [63:0]   rsp_out_name_low;
   logic [63:0]   rsp_out_name_high;
   logic          rsp_has_entry;
   logic [6:0]    rsp_entry_count;
   logic [47:0]   rsp_new_counter;
   logic          rsp_status;
   logic          rsp_last;

   // Register port.
   logic          csr_psel    = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite  = 1'b0;
   logic [2:0]    csr_paddr   = '0;
   logic [31:0]   csr_pwdata  = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // Shadow copy of the ring, its pointers and the filter registers.
   entry_type     ring_store [DEPTH];
   int            ring_head = 0;
   int            ring_tail = 0;
   bit            ring_is_empty = 1'b1;
   logic [47:0]   events_total = '0;
   bit            read_parked = 1'b0;
   logic [47:0]   parked_target = '0;
   logic [1:0]    mode_cfg = FILT_OFF;
   logic [21:0]   group_cfg = '0;

   req_type       pending_beats [$];
   rsp_type       answer_q [$];
   logic [47:0]   gen_total = '0;
   bit            no_idle = 1'b0;
   int            send_gap = 0;
   int            hold_left = 0;
   int            error_count = 0;
   int            beats_sent = 0;
   int            answers_seen = 0;
   int            settings_done = 0;
   int            cycle_count = 0;

   assign req_kind            = beat_on_bus.kind;
   assign req_quit_state      = beat_on_bus.quit_state;
   assign req_option_state    = beat_on_bus.option_state;
   assign req_task_state      = beat_on_bus.task_state;
   assign req_group_id        = beat_on_bus.group_id;
   assign req_thread_id       = beat_on_bus.thread_id;
   assign req_name_low        = beat_on_bus.name_low;
   assign req_name_high       = beat_on_bus.name_high;
   assign req_request_counter = beat_on_bus.request_counter;

   filtered_trace_ring_buffer #(
      .RING_DEPTH(DEPTH)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_quit_state      (req_quit_state),
      .req_option_state    (req_option_state),
      .req_task_state      (req_task_state),
      .req_group_id        (req_group_id),
      .req_thread_id       (req_thread_id),
      .req_name_low        (req_name_low),
      .req_name_high       (req_name_high),
      .req_request_counter (req_request_counter),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_state       (rsp_out_state),
      .rsp_out_group_id    (rsp_out_group_id),
      .rsp_out_thread_id   (rsp_out_thread_id),
      .rsp_out_name_low    (rsp_out_name_low),
      .rsp_out_name_high   (rsp_out_name_high),
      .rsp_has_entry       (rsp_has_entry),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_new_counter     (rsp_new_counter),
      .rsp_status          (rsp_status),
      .rsp_last            (rsp_last),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #2 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycle_count);
         $display("filtered_trace_ring_buffer verification failed");
         $finish;
      end
   end

   function automatic bit passes_filter(logic [21:0] group);
      return mode_cfg == FILT_ALL || (mode_cfg == FILT_GROUP && group == group_cfg);
   endfunction

   function automatic int ring_fill();
      if (ring_is_empty) return 0;
      if (ring_head == ring_tail) return DEPTH;
      return (ring_tail + DEPTH - ring_head) % DEPTH;
   endfunction

   // Queue one answer run: the oldest entries up to the limit, or one empty beat.
   function automatic void emit_answer_run(int limit, logic [47:0] counter);
      int count;
      int slot;
      int k;
      rsp_type r;
      count = ring_fill();
      if (limit < count) count = limit;
      r = '0;
      r.new_counter = counter;
      r.status = STATUS_OK;
      r.last = 1'b1;
      if (count == 0) begin
         answer_q.push_back(r);
         return;
      end
      slot = ring_head;
      for (k = 0; k < count; k++) begin
         r.entry = ring_store[slot];
         r.has_entry = 1'b1;
         r.entry_count = 7'(count);
         r.last = (k == count - 1);
         answer_q.push_back(r);
         slot = (slot + 1) % DEPTH;
      end
   endfunction

   // A target still ahead gets a full run; one passed by a whole ring is stale.
   function automatic void answer_for_target(logic [47:0] target);
      logic [47:0] lag;
      if (target > events_total) begin
         emit_answer_run(DEPTH, target);
      end else begin
         lag = events_total - target;
         if (lag >= DEPTH) emit_answer_run(0, events_total);
         else emit_answer_run(DEPTH - int'(lag), target);
      end
   endfunction

   // Update the shadow ring with one accepted beat and queue what it answers.
   function automatic void predict_beat(req_type b);
      logic [48:0] padded;
      logic [47:0] target;
      rsp_type busy;
      case (b.kind)
         KIND_ADD: begin
            if (passes_filter(b.group_id)) begin
               if (b.quit_state == QUIT_ZOMBIE || b.quit_state == QUIT_DEAD) begin
                  ring_store[ring_tail].state = {24'd0, b.quit_state};
               end else if (b.option_state != '0) begin
                  ring_store[ring_tail].state = b.option_state;
               end else begin
                  ring_store[ring_tail].state = b.task_state;
               end
               ring_store[ring_tail].group_id = b.group_id;
               ring_store[ring_tail].thread_id = b.thread_id;
               ring_store[ring_tail].name_low = b.name_low;
               ring_store[ring_tail].name_high = b.name_high;
               events_total = events_total + 48'd1;
               // A full ring drops its oldest entry.
               if (ring_is_empty) ring_is_empty = 1'b0;
               else if (ring_head == ring_tail) ring_head = (ring_head + 1) % DEPTH;
               ring_tail = (ring_tail + 1) % DEPTH;
               if (read_parked && parked_target <= events_total) begin
                  read_parked = 1'b0;
                  answer_for_target(parked_target);
               end
            end
         end
         KIND_READ: begin
            if (b.request_counter == '0) begin
               emit_answer_run(events_total < DEPTH ? int'(events_total) : DEPTH,
                               events_total);
            end else begin
               padded = {1'b0, b.request_counter} + 49'(DEPTH);
               target = padded[48] ? '1 : padded[47:0];
               if (target <= events_total) begin
                  answer_for_target(target);
               end else if (read_parked) begin
                  busy = '0;
                  busy.status = STATUS_BUSY;
                  busy.last = 1'b1;
                  answer_q.push_back(busy);
               end else begin
                  read_parked = 1'b1;
                  parked_target = target;
               end
            end
         end
         KIND_CLEAR: begin
            if (read_parked) begin
               read_parked = 1'b0;
               answer_for_target(parked_target);
            end
            ring_head = ring_tail;
            ring_is_empty = 1'b1;
         end
         default: begin
         end
      endcase
   endfunction

   // Request driver: one beat at a time from the pending queue, with random gaps.
   always @(posedge clock) begin : drive_requests
      int gap;
      bit fetch_next;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         fetch_next = 1'b0;
         if (req_valid && !req_stall) begin
            predict_beat(beat_on_bus);
            beats_sent++;
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap == 0) begin
               fetch_next = 1'b1;
            end else begin
               req_valid <= 1'b0;
               send_gap <= gap - 1;
            end
         end else if (!req_valid) begin
            if (send_gap != 0) send_gap <= send_gap - 1;
            else fetch_next = 1'b1;
         end
         if (fetch_next) begin
            if (pending_beats.size() != 0) begin
               beat_on_bus <= pending_beats.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
         $error("%s: expected %h, actual %h", field, want, seen);
         error_count++;
      end
   endfunction

   // Answer monitor: compare each accepted beat with the oldest expectation.
   always @(posedge clock) begin : take_answers
      rsp_type got;
      rsp_type want;
      int hold;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         got.entry.state = rsp_out_state;
         got.entry.group_id = rsp_out_group_id;
         got.entry.thread_id = rsp_out_thread_id;
         got.entry.name_low = rsp_out_name_low;
         got.entry.name_high = rsp_out_name_high;
         got.has_entry = rsp_has_entry;
         got.entry_count = rsp_entry_count;
         got.new_counter = rsp_new_counter;
         got.status = rsp_status;
         got.last = rsp_last;
         answers_seen++;
         if (answer_q.size() == 0) begin
            $error("Answer beat with nothing expected: %p", got);
            error_count++;
         end else begin
            want = answer_q.pop_front();
            check_field("out_state", want.entry.state, got.entry.state);
            check_field("out_group_id", want.entry.group_id, got.entry.group_id);
            check_field("out_thread_id", want.entry.thread_id, got.entry.thread_id);
            check_field("out_name_low", want.entry.name_low, got.entry.name_low);
            check_field("out_name_high", want.entry.name_high, got.entry.name_high);
            check_field("has_entry", want.has_entry, got.has_entry);
            check_field("entry_count", want.entry_count, got.entry_count);
            check_field("new_counter", want.new_counter, got.new_counter);
            check_field("status", want.status, got.status);
            check_field("last", want.last, got.last);
         end
         hold = no_idle ? 0 : $urandom_range(0, 3);
         hold_left <= hold;
         rsp_stall <= (hold != 0);
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end
   end

   // Register write followed by a read back of the same register.
   task automatic csr_write(input logic idx, input logic [31:0] value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == REG_FILTER_MODE) begin
         mode_cfg = value[1:0];
         readback = {30'd0, mode_cfg};
      end else begin
         group_cfg = value[21:0];
         readback = {10'd0, group_cfg};
      end
      settings_done++;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== readback) begin
         $error("register %0d readback: expected %h, actual %h", idx, readback, csr_prdata);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Wait until every beat is sent and answered, then let trailing work settle.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || answer_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic req_type random_beat(logic [1:0] kind);
      req_type b;
      b.kind = kind;
      case ($urandom_range(0, 5))
         0: b.quit_state = QUIT_ZOMBIE;
         1: b.quit_state = QUIT_DEAD;
         default: b.quit_state = 8'($urandom);
      endcase
      b.option_state = ($urandom_range(0, 2) == 0) ? '0 : 32'($urandom);
      b.task_state = $urandom;
      b.group_id = 22'($urandom);
      b.thread_id = 22'($urandom);
      b.name_low = {$urandom, $urandom};
      b.name_high = {$urandom, $urandom};
      b.request_counter = 48'({$urandom, $urandom});
      return b;
   endfunction

   // Queue a beat; returns whether the block does anything with it.
   function automatic bit queue_beat(req_type b);
      bit counts;
      pending_beats.push_back(b);
      counts = 1'b1;
      if (b.kind == KIND_UNUSED) begin
         counts = 1'b0;
      end else if (b.kind == KIND_ADD) begin
         if (passes_filter(b.group_id)) gen_total = gen_total + 48'd1;
         else counts = 1'b0;
      end
      return counts;
   endfunction

   // One random phase under a fresh filter setting.
   task automatic run_random_phase(logic [1:0] mode, logic [21:0] group, bit quiet,
                                   int effective, int add_pct);
      int made;
      int pick;
      logic [47:0] rc;
      req_type b;
      wait_idle();
      csr_write(REG_FILTER_MODE, {30'd0, mode});
      csr_write(REG_FILTER_GROUP, {10'd0, group});
      @(negedge clock);
      no_idle = quiet;
      made = 0;
      while (made < effective) begin
         pick = $urandom_range(0, 99);
         if (pick < add_pct) begin
            b = random_beat(KIND_ADD);
            if (mode == FILT_GROUP && $urandom_range(0, 3) != 0) b.group_id = group_cfg;
         end else if (pick < add_pct + (100 - add_pct) * 2 / 3) begin
            // Reads aimed around the running total: now, partial, stale and parked.
            b = random_beat(KIND_READ);
            case ($urandom_range(0, 9))
               0, 1:    rc = '0;
               2, 3, 4: rc = gen_total - 48'($urandom_range(0, 140));
               5, 6:    rc = gen_total - 48'(DEPTH) + 48'($urandom_range(1, 6));
               7:       rc = 48'({$urandom, $urandom});
               8:       rc = '1 - 48'($urandom_range(0, 70));
               default: rc = 48'($urandom_range(1, 3));
            endcase
            b.request_counter = rc;
         end else if (pick < 97) begin
            b = random_beat(KIND_CLEAR);
         end else begin
            b = random_beat(KIND_UNUSED);
         end
         if (queue_beat(b)) made++;
      end
   endtask

   initial begin : run_phases
      req_type b;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Tracing off: adds vanish and a read now sees an empty ring.
      csr_write(REG_FILTER_MODE, {30'd0, FILT_OFF});
      csr_write(REG_FILTER_GROUP, 32'd0);
      @(negedge clock);
      b = random_beat(KIND_ADD);
      void'(queue_beat(b));
      b = random_beat(KIND_READ);
      b.request_counter = '0;
      void'(queue_beat(b));
      b = random_beat(KIND_UNUSED);
      void'(queue_beat(b));
      wait_idle();

      // Trace all: each way of choosing the recorded state, field extremes.
      csr_write(REG_FILTER_MODE, {30'd0, FILT_ALL});
      @(negedge clock);
      b = random_beat(KIND_ADD);
      b.quit_state = QUIT_ZOMBIE;
      b.option_state = '1;
      void'(queue_beat(b));
      b = random_beat(KIND_ADD);
      b.quit_state = QUIT_DEAD;
      void'(queue_beat(b));
      b = random_beat(KIND_ADD);
      b.quit_state = 8'd0;
      b.option_state = b.option_state | 32'd1;
      void'(queue_beat(b));
      b = random_beat(KIND_ADD);
      b.quit_state = '1;
      b.option_state = '0;
      b.task_state = '1;
      b.group_id = '1;
      b.thread_id = '1;
      b.name_low = '1;
      b.name_high = '1;
      void'(queue_beat(b));
      b = '0;
      b.kind = KIND_ADD;
      void'(queue_beat(b));
      b = random_beat(KIND_READ);
      b.request_counter = '0;
      void'(queue_beat(b));
      // Park a read, then a second waiting read is refused as busy.
      b = random_beat(KIND_READ);
      b.request_counter = 48'd1;
      void'(queue_beat(b));
      b = random_beat(KIND_READ);
      b.request_counter = 48'd5;
      void'(queue_beat(b));
      b = random_beat(KIND_ADD);
      void'(queue_beat(b));
      // A clear answers the parked read before emptying the ring.
      b = random_beat(KIND_CLEAR);
      void'(queue_beat(b));
      b = random_beat(KIND_READ);
      b.request_counter = '0;
      void'(queue_beat(b));
      // The largest counter saturates the target.
      b = random_beat(KIND_READ);
      b.request_counter = '1;
      void'(queue_beat(b));
      b = random_beat(KIND_UNUSED);
      void'(queue_beat(b));
      b = random_beat(KIND_CLEAR);
      void'(queue_beat(b));
      b = random_beat(KIND_ADD);
      void'(queue_beat(b));
      b = random_beat(KIND_ADD);
      void'(queue_beat(b));
      b = random_beat(KIND_CLEAR);
      void'(queue_beat(b));

      // Random phases across the filter settings, with and without idling.
      run_random_phase(FILT_ALL, 22'($urandom), 1'b0, 40, 75);
      run_random_phase(FILT_GROUP, 22'($urandom), 1'b0, 30, 65);
      run_random_phase(FILT_GROUP, '1, 1'b1, 20, 65);
      run_random_phase(FILT_GROUP, '0, 1'b0, 20, 65);
      run_random_phase(FILT_UNUSED, 22'($urandom), 1'b0, 8, 60);
      run_random_phase(FILT_OFF, 22'($urandom), 1'b0, 8, 60);
      run_random_phase(FILT_ALL, 22'($urandom), 1'b1, 40, 60);
      run_random_phase(FILT_ALL, 22'($urandom), 1'b0, 20, 60);
      wait_idle();

      $display("Sent %0d request beats and checked %0d answer beats.", beats_sent,
               answers_seen);
      $display("Went through %0d register writes; %0d events stored in total.",
               settings_done, events_total);
      if (error_count == 0) begin
         $display("filtered_trace_ring_buffer verification clean");
      end else begin
         $display("filtered_trace_ring_buffer verification failed");
      end
      $finish;
   end

endmodule

@@ filtered_trace_ring_buffer.f @@
+incdir+hdl
hdl/ftrb_pkg.sv
hdl/ftrb_ram.sv
hdl/ftrb_ctrl.sv
hdl/ftrb_dp.sv
hdl/filtered_trace_ring_buffer.sv
sim/filtered_trace_ring_buffer_tb.sv
